// ----- design/assert_macros.svh -----
// assertion helpers included by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/dfstm_pkg.sv -----
`default_nettype none

package dfstm_pkg;

  // fixed field widths
  localparam int IdW        = 5;
  localparam int RowW       = 32;
  localparam int StampW     = 7;
  localparam int VcW        = 6;
  localparam int ResultCap  = 32;

  // defaults
  localparam int          MaxVerticesDflt = 32;
  localparam logic [5:0]  VertexCountRst  = 6'd32;

  // operation codes
  localparam logic FuncLoad = 1'b0;
  localparam logic FuncRun  = 1'b1;

  // sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StPop,
    StRoot,
    StOutRd,
    StOutWr
  } dfstm_state_e;

  // input beat
  typedef struct packed {
    logic             func;
    logic [IdW-1:0]   row_index;
    logic [RowW-1:0]  row_bits;
    logic [IdW-1:0]   start_vertex;
  } dfstm_in_t;

  // result beat
  typedef struct packed {
    logic [IdW-1:0]    vertex_id;
    logic [StampW-1:0] discovery_time;
    logic [StampW-1:0] finish_time;
    logic [IdW-1:0]    parent_vertex;
    logic              has_parent;
    logic              last;
  } dfstm_res_t;

endpackage

`default_nettype wire

// ----- design/dfstm_ram.sv -----
`default_nettype none

// one write port, one registered read port
module dfstm_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- design/dfs_timestamps_matrix_top.sv -----
// channel   dir  handshake                      payload
// input     in   start high, busy low           item_i (dfstm_pkg::dfstm_in_t)
// config    in   cfg_valid_i and cfg_ready_o    cfg_data_i (vertex count, 6 bits)
// result    out  res_valid_o, one-cycle strobe  res_o (dfstm_pkg::dfstm_res_t)
//
// a load beat writes one adjacency row if its index is in range; busy stays low
// a run scans the current vertex's row one adjacency bit at a time, pops the stack to resume
// a suspended vertex, checks each vertex in index order as a restart root, then reads results
// results come in vertex order, not back to back, and busy falls with the last one
// the receiver cannot stall the results
// reset clears the sequencer, counters and flags; vertex count resets to 32
`default_nettype none

`include "assert_macros.svh"

module dfs_timestamps_matrix_top #(
  parameter int MAX_VERTICES = dfstm_pkg::MaxVerticesDflt
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire dfstm_pkg::dfstm_in_t  item_i,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [dfstm_pkg::VcW-1:0] cfg_data_i,
  output logic                       res_valid_o,
  output dfstm_pkg::dfstm_res_t      res_o
);

  localparam int NumV   = (MAX_VERTICES < dfstm_pkg::ResultCap) ?
                          MAX_VERTICES : dfstm_pkg::ResultCap;
  localparam int VW     = $clog2(NumV);
  localparam int JW     = $clog2(NumV + 1);
  localparam int FrameW = VW + JW;
  localparam int SW     = dfstm_pkg::StampW;
  localparam int RowW_L = dfstm_pkg::RowW;

  // registers
  dfstm_pkg::dfstm_state_e state_q, state_d;
  logic [dfstm_pkg::VcW-1:0] vc_q, vc_d;
  logic [JW-1:0]   n_q, n_d;
  logic [SW-1:0]   time_q, time_d;
  logic [JW-1:0]   depth_q, depth_d;
  logic [VW-1:0]   cur_u_q, cur_u_d;
  logic [JW-1:0]   cur_j_q, cur_j_d;
  logic [JW-1:0]   root_q, root_d;
  logic [NumV-1:0] visited_q, visited_d;
  logic [NumV-1:0] pok_q, pok_d;
  dfstm_pkg::dfstm_res_t res_q, res_d;
  logic            res_valid_q, res_valid_d;

  // control
  logic          accept;
  logic          run_go;
  logic          load_go;
  logic          s_in_range;
  logic [JW-1:0] n_run;
  logic          disc_en;
  logic [VW-1:0] disc_v;
  logic          push_en;
  logic          fin_en;
  logic          pop_rd;
  logic          par_we;
  logic          out_re;
  logic          scan_end;
  logic          scan_hit;
  logic          root_end;
  logic          root_white;
  logic          out_last;
  logic [SW-1:0] time_base;
  logic [SW-1:0] stamp;
  logic [JW-1:0] depth_m1;
  logic [JW-1:0] depth_m2;
  logic [JW-1:0] j_next;

  // memory ports
  logic                adj_re;
  logic [VW-1:0]       adj_raddr;
  logic [RowW_L-1:0]   adj_rdata;
  logic [SW-1:0]       st_rdata;
  logic [SW-1:0]       en_rdata;
  logic [VW-1:0]       par_rdata;
  logic [FrameW-1:0]   stk_rdata;
  logic [VW-1:0]       frame_u;
  logic [JW-1:0]       frame_j;

  // handshakes
  assign busy        = (state_q != dfstm_pkg::StIdle);
  assign cfg_ready_o = !busy;
  assign accept      = start && !busy;
  assign load_go     = accept && (item_i.func == dfstm_pkg::FuncLoad);
  assign run_go      = accept && (item_i.func == dfstm_pkg::FuncRun);

  // vertex count clamped to 1..NumV
  always_comb begin
    if (vc_q == '0) begin
      n_run = JW'(1);
    end else if (vc_q > dfstm_pkg::VcW'(NumV)) begin
      n_run = JW'(NumV);
    end else begin
      n_run = JW'(vc_q);
    end
  end

  assign s_in_range = ({1'b0, item_i.start_vertex} < dfstm_pkg::VcW'(n_run));

  // scan and restart decisions
  assign scan_end   = (cur_j_q >= n_q);
  assign scan_hit   = !scan_end && adj_rdata[cur_j_q[VW-1:0]] &&
                      !visited_q[cur_j_q[VW-1:0]];
  assign root_end   = (root_q >= n_q);
  assign root_white = !root_end && !visited_q[root_q[VW-1:0]];
  assign out_last   = (root_q == n_q - JW'(1));

  // stamp counter restarts with each run
  assign time_base = (state_q == dfstm_pkg::StIdle) ? '0 : time_q;
  assign stamp     = time_base + SW'(1);
  assign depth_m1  = depth_q - JW'(1);
  assign depth_m2  = depth_q - JW'(2);
  assign j_next    = cur_j_q + JW'(1);
  assign frame_u   = stk_rdata[FrameW-1 -: VW];
  assign frame_j   = stk_rdata[JW-1:0];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dfstm_pkg::StIdle: begin
        if (run_go) begin
          state_d = s_in_range ? dfstm_pkg::StScan : dfstm_pkg::StRoot;
        end
      end
      dfstm_pkg::StScan: begin
        if (!scan_hit && scan_end) begin
          state_d = (depth_q > JW'(1)) ? dfstm_pkg::StPop : dfstm_pkg::StRoot;
        end
      end
      dfstm_pkg::StPop: begin
        state_d = dfstm_pkg::StScan;
      end
      dfstm_pkg::StRoot: begin
        if (root_end) begin
          state_d = dfstm_pkg::StOutRd;
        end else if (root_white) begin
          state_d = dfstm_pkg::StScan;
        end
      end
      dfstm_pkg::StOutRd: begin
        state_d = dfstm_pkg::StOutWr;
      end
      dfstm_pkg::StOutWr: begin
        state_d = out_last ? dfstm_pkg::StIdle : dfstm_pkg::StOutRd;
      end
      default: begin
        state_d = dfstm_pkg::StIdle;
      end
    endcase
  end

  // sequencer outputs
  always_comb begin
    disc_en = 1'b0;
    disc_v  = '0;
    push_en = 1'b0;
    fin_en  = 1'b0;
    pop_rd  = 1'b0;
    par_we  = 1'b0;
    out_re  = 1'b0;
    unique case (state_q)
      dfstm_pkg::StIdle: begin
        if (run_go && s_in_range) begin
          disc_en = 1'b1;
          disc_v  = item_i.start_vertex[VW-1:0];
        end
      end
      dfstm_pkg::StScan: begin
        if (scan_hit) begin
          push_en = 1'b1;
          par_we  = 1'b1;
          disc_en = 1'b1;
          disc_v  = cur_j_q[VW-1:0];
        end else if (scan_end) begin
          fin_en = 1'b1;
          pop_rd = (depth_q > JW'(1));
        end
      end
      dfstm_pkg::StRoot: begin
        if (root_white) begin
          disc_en = 1'b1;
          disc_v  = root_q[VW-1:0];
        end
      end
      dfstm_pkg::StOutRd: begin
        out_re = 1'b1;
      end
      dfstm_pkg::StPop, dfstm_pkg::StOutWr: begin
      end
      default: begin
      end
    endcase
  end

  assign adj_re    = disc_en || (state_q == dfstm_pkg::StPop);
  assign adj_raddr = disc_en ? disc_v : frame_u;

  // datapath next values
  always_comb begin
    vc_d        = vc_q;
    n_d         = n_q;
    time_d      = time_q;
    depth_d     = depth_q;
    cur_u_d     = cur_u_q;
    cur_j_d     = cur_j_q;
    root_d      = root_q;
    visited_d   = visited_q;
    pok_d       = pok_q;
    res_d       = res_q;
    res_valid_d = 1'b0;

    if (cfg_valid_i && cfg_ready_o) begin
      vc_d = cfg_data_i;
    end

    // run start clears the per-run state
    if (run_go) begin
      n_d       = n_run;
      time_d    = '0;
      depth_d   = '0;
      root_d    = '0;
      visited_d = '0;
      pok_d     = '0;
    end

    // neighbor step or vertex finish
    if (state_q == dfstm_pkg::StScan && !scan_hit) begin
      if (scan_end) begin
        time_d  = time_q + SW'(1);
        depth_d = depth_m1;
      end else begin
        cur_j_d = j_next;
      end
    end

    if (par_we) begin
      pok_d[cur_j_q[VW-1:0]] = 1'b1;
    end

    // discover a vertex: new frame on top
    if (disc_en) begin
      time_d            = stamp;
      visited_d[disc_v] = 1'b1;
      cur_u_d           = disc_v;
      cur_j_d           = '0;
      depth_d           = (state_q == dfstm_pkg::StIdle) ? JW'(1) : depth_q + JW'(1);
    end

    // restart scan over vertices in index order
    if (state_q == dfstm_pkg::StRoot) begin
      root_d = root_end ? '0 : root_q + JW'(1);
    end

    // resume the suspended frame
    if (state_q == dfstm_pkg::StPop) begin
      cur_u_d = frame_u;
      cur_j_d = frame_j;
    end

    // result beat
    if (state_q == dfstm_pkg::StOutWr) begin
      res_valid_d          = 1'b1;
      res_d.vertex_id      = dfstm_pkg::IdW'(root_q[VW-1:0]);
      res_d.discovery_time = st_rdata;
      res_d.finish_time    = en_rdata;
      res_d.has_parent     = pok_q[root_q[VW-1:0]];
      res_d.parent_vertex  = pok_q[root_q[VW-1:0]] ?
                             dfstm_pkg::IdW'(par_rdata) : '0;
      res_d.last           = out_last;
      root_d               = root_q + JW'(1);
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dfstm_pkg::StIdle;
      vc_q        <= dfstm_pkg::VertexCountRst;
      n_q         <= JW'(NumV);
      time_q      <= '0;
      depth_q     <= '0;
      cur_u_q     <= '0;
      cur_j_q     <= '0;
      root_q      <= '0;
      visited_q   <= '0;
      pok_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vc_q        <= vc_d;
      n_q         <= n_d;
      time_q      <= time_d;
      depth_q     <= depth_d;
      cur_u_q     <= cur_u_d;
      cur_j_q     <= cur_j_d;
      root_q      <= root_d;
      visited_q   <= visited_d;
      pok_q       <= pok_d;
      res_valid_q <= res_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // adjacency rows
  dfstm_ram #(.Width(RowW_L), .Depth(NumV)) u_adj (
    .clk_i   (clk_i),
    .we_i    (load_go && ({1'b0, item_i.row_index} < dfstm_pkg::VcW'(NumV))),
    .waddr_i (item_i.row_index[VW-1:0]),
    .wdata_i (item_i.row_bits),
    .re_i    (adj_re),
    .raddr_i (adj_raddr),
    .rdata_o (adj_rdata)
  );

  // discovery stamps
  dfstm_ram #(.Width(SW), .Depth(NumV)) u_start (
    .clk_i   (clk_i),
    .we_i    (disc_en),
    .waddr_i (disc_v),
    .wdata_i (stamp),
    .re_i    (out_re),
    .raddr_i (root_q[VW-1:0]),
    .rdata_o (st_rdata)
  );

  // finish stamps
  dfstm_ram #(.Width(SW), .Depth(NumV)) u_end (
    .clk_i   (clk_i),
    .we_i    (fin_en),
    .waddr_i (cur_u_q),
    .wdata_i (time_q + SW'(1)),
    .re_i    (out_re),
    .raddr_i (root_q[VW-1:0]),
    .rdata_o (en_rdata)
  );

  // predecessors
  dfstm_ram #(.Width(VW), .Depth(NumV)) u_parent (
    .clk_i   (clk_i),
    .we_i    (par_we),
    .waddr_i (cur_j_q[VW-1:0]),
    .wdata_i (cur_u_q),
    .re_i    (out_re),
    .raddr_i (root_q[VW-1:0]),
    .rdata_o (par_rdata)
  );

  // suspended frames: vertex and next neighbor
  dfstm_ram #(.Width(FrameW), .Depth(NumV)) u_stack (
    .clk_i   (clk_i),
    .we_i    (push_en),
    .waddr_i (depth_m1[VW-1:0]),
    .wdata_i ({cur_u_q, j_next}),
    .re_i    (pop_rd),
    .raddr_i (depth_m2[VW-1:0]),
    .rdata_o (stk_rdata)
  );

  // checks
  `ASSERT_IMPLIES(a_depth_bound, busy, depth_q <= n_q, "stack deeper than vertex count")
  `ASSERT_IMPLIES(a_root_empty, state_q == dfstm_pkg::StRoot, depth_q == '0, "restart with stack not empty")
  `ASSERT_NEXT(a_last_ends, res_valid_o && res_o.last, !res_valid_o, "beat after last result")
  `ASSERT_IMPLIES(a_scan_frame, state_q == dfstm_pkg::StScan, depth_q != '0 && cur_j_q <= n_q, "scan without a frame")

endmodule

`default_nettype wire
